### hdl/mlwu_pkg.sv
package mlwu_pkg;

    // request type codes
    localparam logic [1:0] REQ_ACK  = 2'd0;
    localparam logic [1:0] REQ_LOSS = 2'd1;
    localparam logic [1:0] REQ_RTT  = 2'd2;

    // configuration register indexes
    localparam logic CFG_MSS     = 1'b0;
    localparam logic CFG_MIN_WIN = 1'b1;

    localparam logic [15:0] MSS_RESET     = 16'd1460;
    localparam logic [31:0] MIN_WIN_RESET = 32'd14600;

    // shared divider datapath
    localparam int DIV_W = 64;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] CNT_Q16  = 6'd48;
    localparam logic [CNT_W-1:0] CNT_SHR  = 6'd17;
    localparam logic [CNT_W-1:0] CNT_SQ   = 6'd33;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [63:0] TOTAL_MAX = 64'h7_FFFF_FFFF;
    localparam logic [31:0] WIN_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] low;
        logic [DIV_W-1:0] den;
        logic [CNT_W-1:0] count;
    } div_req_t;

endpackage

### hdl/mlwu_ram.sv
module mlwu_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 8,
        parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mlwu_div.sv
module mlwu_div
    import mlwu_pkg::*;
    (
        input  logic             clk,
        input  logic             rst_n,
        input  div_req_t         req,
        output logic [DIV_W-1:0] quot,
        output logic             done
    );

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] low_reg, low_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    // one restoring step: shift in a numerator bit, compare, subtract
    always_comb
    begin
        trial     = {rem_reg, low_reg[DIV_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            rem_next  = req.rem_init;
            low_next  = req.low;
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            low_next  = {low_reg[DIV_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

`ifndef NO_ASSERTIONS
    // a new division only once the previous one has finished
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    // completion ends the iteration
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");
    // a running division always has steps left
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider running with zero step count");
`endif

endmodule

### hdl/multipath_linked_window_update.sv
// loss, rtt and invalid requests and acks on an inactive subflow go from acceptance via
// ST_READ and ST_LOOK to ST_OUT; other acks walk every slot, two divisions per active
// one, then share and square divisions unless the share is zero and an inverse one on
// the shared bit-serial divider, one quotient bit per cycle; a request is taken only in
// ST_IDLE; done is high for one cycle and cannot be held off by the receiver
// reset (rst_n, asynchronous): all subflows inactive, mss and min_window defaults
module multipath_linked_window_update
    import mlwu_pkg::*;
    #(
        parameter int NUM_SUBFLOWS = 8
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        start,
        output logic        busy,
        input  logic [1:0]  req_type,
        input  logic [2:0]  subflow,
        input  logic [15:0] length,
        input  logic [23:0] rtt_us,
        output logic        done,
        output logic [2:0]  subflow_res,
        output logic [31:0] window,
        output logic [34:0] total_window,
        input  logic        cfg_valid,
        output logic        cfg_ready,
        input  logic        cfg_index,
        input  logic [31:0] cfg_data
    );

    localparam int IDX_W = (NUM_SUBFLOWS > 1) ? $clog2(NUM_SUBFLOWS) : 1;
    localparam int TOT_W = 33 + $clog2(NUM_SUBFLOWS);
    localparam int S_W   = 48 + $clog2(NUM_SUBFLOWS);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'b000000000000000001,
        ST_READ     = 18'b000000000000000010,
        ST_LOOK     = 18'b000000000000000100,
        ST_WALK_RD  = 18'b000000000000001000,
        ST_WALK_CHK = 18'b000000000000010000,
        ST_DIV_Q    = 18'b000000000000100000,
        ST_DIV_P    = 18'b000000000001000000,
        ST_NEXT     = 18'b000000000010000000,
        ST_FACT     = 18'b000000000100000000,
        ST_DIV_U    = 18'b000000001000000000,
        ST_SQR      = 18'b000000010000000000,
        ST_DIV_A    = 18'b000000100000000000,
        ST_INV      = 18'b000001000000000000,
        ST_DIV_I    = 18'b000010000000000000,
        ST_RATIO    = 18'b000100000000000000,
        ST_MUL      = 18'b001000000000000000,
        ST_UPDATE   = 18'b010000000000000000,
        ST_OUT      = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]             mss_reg;
    logic [31:0]             min_win_reg;
    logic [NUM_SUBFLOWS-1:0] active_reg, active_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    found_reg, found_next;

    logic [1:0]  type_reg;
    logic [2:0]  sf_reg;
    logic [15:0] len_reg;
    logic [23:0] rtt_reg;
    logic [31:0] w_ack_reg, w_ack_next;
    logic [31:0] cw_i_reg, cw_i_next;
    logic [23:0] r_i_reg, r_i_next;
    logic [47:0] q_reg, q_next;
    logic [S_W-1:0] s_reg, s_next;
    logic [47:0] best_reg, best_next;
    logic [47:0] qk_reg, qk_next;
    logic [31:0] wk_reg, wk_next;
    logic [16:0] u_reg, u_next;
    logic [16:0] a_reg, a_next;
    logic [16:0] inv_reg, inv_next;
    logic [16:0] ratio_reg, ratio_next;
    logic [31:0] lm_reg, lm_next;
    logic [48:0] prod_reg, prod_next;
    logic [31:0] win_reg, win_next;

    logic [IDX_W-1:0] sf_addr;
    logic             sf_ok;
    logic [IDX_W-1:0] raddr;
    logic             cwnd_we, srtt_we;
    logic [31:0]      cwnd_wdata, cwnd_rd;
    logic [23:0]      srtt_wdata, srtt_rd;
    logic [23:0]      r_rd;
    logic [31:0]      half_w;
    logic [33:0]      sum_w;
    logic [33:0]      u_sq;

    div_req_t         div_req;
    logic [DIV_W-1:0] div_quot;
    logic             div_done;

    assign sf_addr = IDX_W'(sf_reg);
    assign sf_ok   = 32'(sf_reg) < NUM_SUBFLOWS;
    assign r_rd    = (srtt_rd == '0) ? 24'd1 : srtt_rd;
    assign half_w  = {1'b0, cwnd_rd[31:1]};
    assign sum_w   = {2'b00, w_ack_reg} + {1'b0, prod_reg[48:16]};
    assign u_sq    = u_reg * u_reg;

    mlwu_ram #(.WIDTH(32), .DEPTH(NUM_SUBFLOWS), .ADDR_W(IDX_W)) u_cwnd (
        .clk   (clk),
        .we    (cwnd_we),
        .waddr (sf_addr),
        .wdata (cwnd_wdata),
        .raddr (raddr),
        .rdata (cwnd_rd)
    );

    mlwu_ram #(.WIDTH(24), .DEPTH(NUM_SUBFLOWS), .ADDR_W(IDX_W)) u_srtt (
        .clk   (clk),
        .we    (srtt_we),
        .waddr (sf_addr),
        .wdata (srtt_wdata),
        .raddr (raddr),
        .rdata (srtt_rd)
    );

    mlwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quot  (div_quot),
        .done  (div_done)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        w_ack_next  = w_ack_reg;
        cw_i_next   = cw_i_reg;
        r_i_next    = r_i_reg;
        q_next      = q_reg;
        s_next      = s_reg;
        best_next   = best_reg;
        qk_next     = qk_reg;
        wk_next     = wk_reg;
        u_next      = u_reg;
        a_next      = a_reg;
        inv_next    = inv_reg;
        ratio_next  = ratio_reg;
        lm_next     = lm_reg;
        prod_next   = prod_reg;
        win_next    = win_reg;
        raddr       = idx_reg;
        cwnd_we     = 1'b0;
        srtt_we     = 1'b0;
        cwnd_wdata  = cwnd_rd;
        srtt_wdata  = (rtt_reg == '0) ? 24'd1 : rtt_reg;
        div_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                raddr      = sf_addr;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = ST_OUT;
                win_next   = '0;
                if (sf_ok)
                begin
                    priority case (type_reg)
                        REQ_RTT:
                        begin
                            srtt_we = 1'b1;
                            if (!active_reg[sf_addr])
                            begin
                                active_next[sf_addr] = 1'b1;
                                cwnd_we    = 1'b1;
                                cwnd_wdata = min_win_reg;
                                total_next = total_reg + TOT_W'(min_win_reg);
                                win_next   = min_win_reg;
                            end
                            else
                            begin
                                win_next = cwnd_rd;
                            end
                        end
                        REQ_LOSS:
                        begin
                            if (active_reg[sf_addr])
                            begin
                                cwnd_we    = 1'b1;
                                cwnd_wdata = (half_w > min_win_reg) ? half_w : min_win_reg;
                                total_next = total_reg - TOT_W'(cwnd_rd)
                                             + TOT_W'(cwnd_wdata);
                                win_next   = cwnd_wdata;
                            end
                        end
                        REQ_ACK:
                        begin
                            if (active_reg[sf_addr])
                            begin
                                w_ack_next = cwnd_rd;
                                idx_next   = '0;
                                s_next     = '0;
                                found_next = 1'b0;
                                state_next = ST_WALK_RD;
                            end
                        end
                        default:
                        begin
                            win_next = active_reg[sf_addr] ? cwnd_rd : 32'd0;
                        end
                    endcase
                end
            end
            ST_WALK_RD:
            begin
                state_next = active_reg[idx_reg] ? ST_WALK_CHK : ST_NEXT;
            end
            ST_WALK_CHK:
            begin
                // w * 2^16 / rtt
                cw_i_next        = cwnd_rd;
                r_i_next         = r_rd;
                div_req.start    = 1'b1;
                div_req.low      = {cwnd_rd, 32'd0};
                div_req.den      = DIV_W'(r_rd);
                div_req.count    = CNT_Q16;
                state_next       = ST_DIV_Q;
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    // (w / rtt) / rtt
                    q_next        = div_quot[47:0];
                    s_next        = s_reg + S_W'(div_quot[47:0]);
                    div_req.start = 1'b1;
                    div_req.low   = {div_quot[47:0], 16'd0};
                    div_req.den   = DIV_W'(r_i_reg);
                    div_req.count = CNT_Q16;
                    state_next    = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_done)
                begin
                    // keep the first subflow with the largest w/rtt^2
                    if (!found_reg || (div_quot[47:0] > best_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = div_quot[47:0];
                        qk_next    = q_reg;
                        wk_next    = cw_i_reg;
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (idx_reg == IDX_W'(NUM_SUBFLOWS - 1))
                begin
                    state_next = ST_FACT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_FACT:
            begin
                if (!found_reg || s_reg == '0 || qk_reg == '0 || wk_reg == '0)
                begin
                    a_next     = '0;
                    state_next = ST_INV;
                end
                else
                begin
                    // share q_k * 2^16 / S; top bits preloaded as q_k <= S
                    div_req.start    = 1'b1;
                    div_req.rem_init = DIV_W'(qk_reg[47:1]);
                    div_req.low      = {qk_reg[0], 63'd0};
                    div_req.den      = DIV_W'(s_reg);
                    div_req.count    = CNT_SHR;
                    state_next       = ST_DIV_U;
                end
            end
            ST_DIV_U:
            begin
                if (div_done)
                begin
                    u_next     = div_quot[16:0];
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                // u^2 / (w_k * 2^16), top bit preloaded as it is below the divisor
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_W'(u_sq[33]);
                div_req.low      = {u_sq[32:0], 31'd0};
                div_req.den      = DIV_W'({wk_reg, 16'd0});
                div_req.count    = CNT_SQ;
                state_next       = ST_DIV_A;
            end
            ST_DIV_A:
            begin
                if (div_done)
                begin
                    a_next     = div_quot[16:0];
                    state_next = ST_INV;
                end
            end
            ST_INV:
            begin
                if (w_ack_reg == '0)
                begin
                    inv_next   = ONE_Q16;
                    state_next = ST_RATIO;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.low   = {ONE_Q16, 47'd0};
                    div_req.den   = DIV_W'(w_ack_reg);
                    div_req.count = CNT_SHR;
                    state_next    = ST_DIV_I;
                end
            end
            ST_DIV_I:
            begin
                if (div_done)
                begin
                    inv_next   = div_quot[16:0];
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                ratio_next = (a_reg < inv_reg) ? a_reg : inv_reg;
                lm_next    = len_reg * mss_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = lm_reg * ratio_reg;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cwnd_we    = 1'b1;
                cwnd_wdata = (sum_w > {2'b00, WIN_MAX}) ? WIN_MAX : sum_w[31:0];
                total_next = total_reg - TOT_W'(w_ack_reg) + TOT_W'(cwnd_wdata);
                win_next   = cwnd_wdata;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            mss_reg     <= MSS_RESET;
            min_win_reg <= MIN_WIN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MSS:     mss_reg     <= cfg_data[15:0];
                    CFG_MIN_WIN: min_win_reg <= cfg_data;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            type_reg <= req_type;
            sf_reg   <= subflow;
            len_reg  <= length;
            rtt_reg  <= rtt_us;
        end
        w_ack_reg <= w_ack_next;
        cw_i_reg  <= cw_i_next;
        r_i_reg   <= r_i_next;
        q_reg     <= q_next;
        s_reg     <= s_next;
        best_reg  <= best_next;
        qk_reg    <= qk_next;
        wk_reg    <= wk_next;
        u_reg     <= u_next;
        a_reg     <= a_next;
        inv_reg   <= inv_next;
        ratio_reg <= ratio_next;
        lm_reg    <= lm_next;
        prod_reg  <= prod_next;
        win_reg   <= win_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = state_reg == ST_OUT;
    assign subflow_res  = sf_reg;
    assign window       = win_reg;
    assign total_window = (64'(total_reg) > TOTAL_MAX) ? TOTAL_MAX[34:0] : 35'(total_reg);
    assign cfg_ready    = 1'b1;

`ifndef NO_ASSERTIONS
    // the result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");
    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");
    // the divider only reports back while the sequencer waits on it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_Q || state_reg == ST_DIV_P ||
                      state_reg == ST_DIV_U || state_reg == ST_DIV_A ||
                      state_reg == ST_DIV_I))
        else $error("divider result with no waiting state");
`endif

endmodule
